FILE: sv/asfp_pkg.sv
// Package of the ASCII sensor frame parser.
// Holds the frame characters, the number limits, the register indexes and the
// control struct between the top level and the number parser. No dependencies.
package asfp_pkg;

  localparam logic [7:0] CHAR_T     = 8'h54;
  localparam logic [7:0] CHAR_H     = 8'h48;
  localparam logic [7:0] CHAR_L     = 8'h4C;
  localparam logic [7:0] CHAR_S     = 8'h53;
  localparam logic [7:0] CHAR_HASH  = 8'h23;
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;

  localparam logic [31:0] MAG_CAP   = 32'h8000_0000;
  localparam logic [31:0] VALUE_MAX = 32'h7FFF_FFFF;

  localparam logic CFG_LIGHT_THR = 1'b0;
  localparam logic CFG_HUMI_THR  = 1'b1;

  localparam logic [15:0] LIGHT_THR_RESET = 16'd2000;
  localparam logic [6:0]  HUMI_THR_RESET  = 7'd70;

  typedef struct packed {
    logic feed;
    logic clear;
  } num_ctrl_t;

endpackage

FILE: sv/asfp_number.sv
// Number parser of the ASCII sensor frame parser: whitespace, sign and digits
// of one field, with saturation to the 32-bit signed range.
// Depends on asfp_pkg.
module asfp_number import asfp_pkg::*; #(
  parameter int FIELD_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  num_ctrl_t   ctrl,
  input  logic [7:0]  rx_byte,
  output logic [31:0] value,
  output logic        field_ok
);

  localparam int LEN_W = $clog2(FIELD_BYTES + 1);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(FIELD_BYTES);

  typedef enum logic [1:0] {
    MODE_SKIP,
    MODE_SIGN,
    MODE_DIGITS,
    MODE_DONE
  } mode_t;

  mode_t            mode;
  logic [LEN_W-1:0] field_length;
  logic             negative;
  logic [31:0]      accumulator;

  logic        is_digit;
  logic        is_space;
  logic        is_sign;
  logic [3:0]  digit_offset;
  logic [35:0] scaled;
  logic [31:0] accumulator_next;

  always_comb begin
    is_digit = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
    is_space = (rx_byte == CHAR_SPACE) || ((rx_byte >= CHAR_TAB) && (rx_byte <= CHAR_CR));
    is_sign  = (rx_byte == CHAR_PLUS) || (rx_byte == CHAR_MINUS);
    digit_offset = rx_byte[3:0];
    scaled = ({4'b0, accumulator} << 3) + ({4'b0, accumulator} << 1)
           + {32'b0, digit_offset};
    accumulator_next = (scaled > {4'b0, MAG_CAP}) ? MAG_CAP : scaled[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      mode         <= MODE_SKIP;
      field_length <= '0;
      negative     <= 1'b0;
      accumulator  <= '0;
    end else if (ctrl.feed) begin
      if (field_length < LEN_MAX) begin
        field_length <= field_length + 1'b1;
      end
      if (mode != MODE_DONE) begin
        priority if (is_digit) begin
          accumulator <= accumulator_next;
          mode        <= MODE_DIGITS;
        end else if (mode == MODE_SKIP && is_space) begin
          mode <= MODE_SKIP;
        end else if (mode == MODE_SKIP && is_sign) begin
          negative <= (rx_byte == CHAR_MINUS);
          mode     <= MODE_SIGN;
        end else begin
          mode <= MODE_DONE;
        end
      end
    end
  end

  always_comb begin
    if (negative) begin
      value = (accumulator >= MAG_CAP) ? MAG_CAP : (32'd0 - accumulator);
    end else begin
      value = (accumulator > VALUE_MAX) ? VALUE_MAX : accumulator;
    end
    field_ok = (field_length != '0) && (field_length < LEN_MAX);
  end

endmodule

FILE: sv/ascii_sensor_frame_parser.sv
// Top level of the ASCII sensor frame parser: frame framing, field split,
// alarm decision and the result register.
// Depends on asfp_pkg and asfp_number.
//
//   channel   signals                                         direction
//   input     in_valid, in_ready, opcode, rx_byte, fire_detected   in
//   result    out_valid, out_ready, frame_ok, temperature, humidity,
//             light_level, buzzer_status, command_valid, command_byte  out
//   config    cfg_write, cfg_index, cfg_data                   in
//
// One byte is taken per cycle while in_ready is high. A beat is parsed from the
// input register when it advances, and a '#' beat loads the result register as
// it is parsed, so the result is registered behind the input register.
// Reset clears the frame, turns the alarm off and loads the default thresholds.
// While a result waits for out_ready the input register holds and in_ready
// drops once it is full.
module ascii_sensor_frame_parser import asfp_pkg::*; #(
  parameter int FRAME_BYTES = 256,
  parameter int FIELD_BYTES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               opcode,
  input  logic [7:0]         rx_byte,
  input  logic               fire_detected,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               frame_ok,
  output logic signed [31:0] temperature,
  output logic signed [31:0] humidity,
  output logic signed [31:0] light_level,
  output logic signed [31:0] buzzer_status,
  output logic               command_valid,
  output logic               command_byte,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int CNT_W = $clog2(FRAME_BYTES);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(FRAME_BYTES - 1);

  typedef enum logic [1:0] {
    PHASE_TEMP,
    PHASE_HUMI,
    PHASE_LIGHT,
    PHASE_BEEP
  } phase_t;

  logic [15:0] light_thr;
  logic [6:0]  humi_thr;

  logic       s_valid;
  logic       s_opcode;
  logic [7:0] s_byte;
  logic       s_fire;
  logic       advance;

  logic [CNT_W-1:0] byte_count;
  phase_t           phase;
  logic             frame_error;
  logic [31:0]      cap_temp;
  logic [31:0]      cap_humi;
  logic [31:0]      cap_light;
  logic             alarm;

  num_ctrl_t   num_ctrl;
  logic [31:0] num_value;
  logic        num_field_ok;

  logic             drop;
  logic             is_end;
  logic             is_sep;
  logic             is_bad_sep;
  logic             first_byte;
  logic             frame_good;
  logic             want;
  logic [CNT_W-1:0] byte_count_next;
  phase_t           phase_next;
  logic             frame_error_next;
  logic             alarm_next;

  asfp_number #(
    .FIELD_BYTES(FIELD_BYTES)
  ) u_number (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (num_ctrl),
    .rx_byte  (s_byte),
    .value    (num_value),
    .field_ok (num_field_ok)
  );

  assign advance  = s_valid && (!out_valid || out_ready);
  assign in_ready = !s_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      light_thr <= LIGHT_THR_RESET;
      humi_thr  <= HUMI_THR_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_LIGHT_THR: light_thr <= cfg_data;
        CFG_HUMI_THR:  humi_thr  <= cfg_data[6:0];
        default:       light_thr <= light_thr;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s_valid <= 1'b1;
    end else if (advance) begin
      s_valid <= 1'b0;
    end
    if (in_valid && in_ready) begin
      s_opcode <= opcode;
      s_byte   <= rx_byte;
      s_fire   <= fire_detected;
    end
  end

  always_comb begin
    drop       = s_opcode || (byte_count >= FULL_COUNT);
    first_byte = (byte_count == '0);
    is_end     = !drop && (s_byte == CHAR_HASH);
    is_sep     = ((phase == PHASE_TEMP) && (s_byte == CHAR_H))
              || ((phase == PHASE_HUMI) && (s_byte == CHAR_L))
              || ((phase == PHASE_LIGHT) && (s_byte == CHAR_S));
    is_bad_sep = ((phase == PHASE_TEMP) && ((s_byte == CHAR_L) || (s_byte == CHAR_S)))
              || ((phase == PHASE_HUMI) && (s_byte == CHAR_S));
    frame_good = !frame_error && !first_byte && (phase == PHASE_BEEP) && num_field_ok;
    want = s_fire
        || (!cap_light[31] && (cap_light > {16'b0, light_thr}))
        || (!cap_humi[31] && (cap_humi > {25'b0, humi_thr}));

    byte_count_next  = byte_count + 1'b1;
    phase_next       = phase;
    frame_error_next = frame_error;
    alarm_next       = alarm;
    num_ctrl         = '{feed: 1'b0, clear: 1'b0};

    priority if (drop || is_end) begin
      byte_count_next  = '0;
      phase_next       = PHASE_TEMP;
      frame_error_next = 1'b0;
      num_ctrl.clear   = 1'b1;
      if (is_end && frame_good) begin
        alarm_next = want;
      end
    end else if (s_byte == CHAR_NUL) begin
      frame_error_next = 1'b1;
    end else if (first_byte) begin
      if (s_byte != CHAR_T) begin
        frame_error_next = 1'b1;
      end
    end else if (is_sep) begin
      if (!num_field_ok) begin
        frame_error_next = 1'b1;
      end
      phase_next     = phase_t'(phase + 2'd1);
      num_ctrl.clear = 1'b1;
    end else if (is_bad_sep) begin
      frame_error_next = 1'b1;
    end else begin
      num_ctrl.feed = 1'b1;
    end

    if (!advance) begin
      num_ctrl = '{feed: 1'b0, clear: 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= '0;
      phase       <= PHASE_TEMP;
      frame_error <= 1'b0;
      alarm       <= 1'b0;
    end else if (advance) begin
      byte_count  <= byte_count_next;
      phase       <= phase_next;
      frame_error <= frame_error_next;
      alarm       <= alarm_next;
    end
    if (advance && !drop && !is_end && (s_byte != CHAR_NUL) && !first_byte && is_sep) begin
      unique case (phase)
        PHASE_TEMP:  cap_temp  <= num_value;
        PHASE_HUMI:  cap_humi  <= num_value;
        PHASE_LIGHT: cap_light <= num_value;
        default:     cap_light <= cap_light;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && is_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (advance && is_end) begin
      frame_ok      <= frame_good;
      temperature   <= frame_good ? cap_temp : 32'd0;
      humidity      <= frame_good ? cap_humi : 32'd0;
      light_level   <= frame_good ? cap_light : 32'd0;
      buzzer_status <= frame_good ? num_value : 32'd0;
      command_valid <= frame_good && (want != alarm);
      command_byte  <= frame_good && (want != alarm) && want;
    end
  end

endmodule
